[rtl/core/ept_pkg.sv]
// Shared types and constants for the encoder period tachometer.
// No dependencies; imported by ept_div and encoder_period_tachometer_core.
`default_nettype none

package ept_pkg;

	// timestamp width default and numerator of the rpm division
	localparam int unsigned TIME_WIDTH_DEF = 32;
	localparam int unsigned NUM_W          = 26;
	localparam logic [NUM_W-1:0] RPM_NUMERATOR = NUM_W'(60000000);
	localparam int unsigned SPEED_W        = 16;
	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

	// configuration registers
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_REV    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT_US = CFG_IDX_W'(1);
	localparam logic [7:0]  SLOTS_RESET   = 8'd16;
	localparam logic [31:0] TIMEOUT_RESET = 32'd500000;

	// request kinds
	localparam logic REQ_PULSE = 1'b0;
	localparam logic REQ_CHECK = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now_us;
	} req_t;

	typedef struct packed {
		logic [15:0] speed_rpm;
		logic        rev_done;
		logic        stalled;
	} rsp_t;

	// divider result handed back to the sequencer
	typedef struct packed {
		logic               done;
		logic [SPEED_W-1:0] rpm;
	} div_res_t;

endpackage

`default_nettype wire

[rtl/core/ept_div.sv]
// Restoring divider: fixed rpm numerator over a time interval, one bit per cycle.
// Depends on ept_pkg.
`default_nettype none

module ept_div #(
	parameter int unsigned TIME_WIDTH = ept_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [TIME_WIDTH-1:0] divisor,
	output ept_pkg::div_res_t          res
);
	import ept_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_WIDTH-1:0] rem_q;
	logic [TIME_WIDTH-1:0] div_q;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      quo_q;

	logic [TIME_WIDTH:0]   trial;
	logic [TIME_WIDTH+1:0] diff;
	logic                  fits;

	// the one shared subtractor: partial remainder minus divisor
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign fits  = ~diff[TIME_WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			num_q <= RPM_NUMERATOR;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	// a zero divisor yields an all-ones quotient, which saturates like a fast shaft
	assign res.done = done_q;
	assign res.rpm  = (|quo_q[NUM_W-1:SPEED_W]) ? SPEED_MAX : quo_q[SPEED_W-1:0];

endmodule

`default_nettype wire

[rtl/core/encoder_period_tachometer_core.sv]
// Top level of the encoder period tachometer: sequencer, state and output register.
// Depends on ept_pkg and ept_div.
`default_nettype none

// Channel | Signals                   | Direction | Transaction
// req     | req_valid, req_ready, req | in        | pulse or stall check + timestamp
// rsp     | rsp_valid, rsp_ready, rsp | out       | speed, rev_done, stalled
// cfg     | cfg_we, cfg_idx, cfg_wdata| in        | register write, no wait
//
// One request transaction at a time. A pulse that completes a revolution is
// accepted, runs the shared subtractor in ept_div once for each of the 26
// quotient bits, has its quotient taken into the speed register, then moves
// into the output register. Every other request goes straight to the write state.
// Reset (arst_n, async) clears count, stamps and speed; registers go to 16 / 500000.
// A stalled rsp channel holds the next finished result in the write state.

module encoder_period_tachometer_core #(
	parameter int unsigned TIME_WIDTH = ept_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire ept_pkg::req_t                      req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output ept_pkg::rsp_t                           rsp,
	input  wire logic                               cfg_we,
	input  wire logic [ept_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [ept_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import ept_pkg::*;

	// compare width covers both the timestamp and the 32-bit timeout
	localparam int unsigned EXT_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIV   = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t state_q;

	logic [7:0]            slots_q;
	logic [31:0]           timeout_q;
	logic [7:0]            count_q;
	logic [TIME_WIDTH-1:0] rev_start_q;
	logic [TIME_WIDTH-1:0] last_pulse_q;
	logic [SPEED_W-1:0]    speed_q;
	logic                  rev_done_q;
	logic                  stalled_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic [EXT_W-1:0]      now_ext;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] interval;
	logic [TIME_WIDTH-1:0] idle_time;
	logic [7:0]            count_inc;
	logic                  rev_hit;
	logic                  timed_out;
	logic                  div_start;
	div_res_t              div_res;
	logic                  rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid & req_ready;

	// timestamps wrap modulo 2^TIME_WIDTH
	assign now_ext   = EXT_W'(req.now_us);
	assign now_t     = now_ext[TIME_WIDTH-1:0];
	assign interval  = now_t - rev_start_q;
	assign idle_time = now_t - last_pulse_q;

	// slots of zero matches after 256 pulses through the 8-bit wrap
	assign count_inc = count_q + 8'd1;
	assign rev_hit   = (count_inc == slots_q);
	assign timed_out = EXT_W'(idle_time) > EXT_W'(timeout_q);

	assign div_start = accept && (req.req_type == REQ_PULSE) && rev_hit;

	ept_div #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.divisor(interval),
		.res    (div_res)
	);

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q   <= SLOTS_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SLOTS_PER_REV:    slots_q   <= cfg_wdata[7:0];
				REG_STALL_TIMEOUT_US: timeout_q <= cfg_wdata[31:0];
				default:              ;
			endcase
		end
	end

	// output register is free when empty or being drained this cycle
	assign rsp_free = ~rsp_valid_q | rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rev_start_q  <= '0;
			last_pulse_q <= '0;
			speed_q      <= '0;
			rev_done_q   <= 1'b0;
			stalled_q    <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			// refill wins over drain when both happen at one edge
			if ((state_q == ST_WRITE) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rev_done_q <= (req.req_type == REQ_PULSE) && rev_hit;
						stalled_q  <= (req.req_type == REQ_CHECK) && timed_out;
						if (req.req_type == REQ_PULSE) begin
							last_pulse_q <= now_t;
							if (rev_hit) begin
								// interval goes to the divider, new revolution starts now
								count_q     <= '0;
								rev_start_q <= now_t;
								state_q     <= ST_DIV;
							end else begin
								count_q <= count_inc;
								state_q <= ST_WRITE;
							end
						end else begin
							// stall check: strict timeout, last pulse stamp untouched
							if (timed_out) begin
								speed_q     <= '0;
								count_q     <= '0;
								rev_start_q <= now_t;
							end
							state_q <= ST_WRITE;
						end
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						speed_q <= div_res.rpm;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WRITE) && rsp_free) begin
			rsp_q.speed_rpm <= speed_q;
			rsp_q.rev_done  <= rev_done_q;
			rsp_q.stalled   <= stalled_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

[test/ept_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the encoder period tachometer: watches the req, rsp and cfg ports,
// predicts every speed reading and compares it field by field with the core's output.
// Depends on ept_pkg; instantiated by the testbench top beside the core.

module tach_checker
	import ept_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_ready,
	input  req_t                  req,
	input  logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int unsigned           mismatches,
	output int unsigned           pending,
	output int unsigned           seen_items,
	output int unsigned           seen_revs,
	output int unsigned           seen_stalls
);

	logic [7:0]  slots_cfg;
	logic [31:0] timeout_cfg;
	logic [7:0]  pulse_cnt;
	logic [31:0] rev_stamp;
	logic [31:0] pulse_stamp;
	logic [15:0] speed_now;
	rsp_t        readings_due[$];

	function automatic logic [15:0] rpm_of(input logic [31:0] span);
		logic [31:0] quot;
		if (span == '0)
			return SPEED_MAX;
		quot = 32'(RPM_NUMERATOR) / span;
		return (quot > 32'(SPEED_MAX)) ? SPEED_MAX : quot[15:0];
	endfunction

	// advances the predicted state by one transaction, returns the reading it causes
	function automatic rsp_t tach_step(input req_t item);
		rsp_t        r;
		logic [31:0] idle;
		r    = '0;
		idle = item.now_us - pulse_stamp;
		if (item.req_type == REQ_PULSE) begin
			pulse_cnt   = pulse_cnt + 8'd1;
			pulse_stamp = item.now_us;
			if (pulse_cnt == slots_cfg) begin
				speed_now  = rpm_of(item.now_us - rev_stamp);
				rev_stamp  = item.now_us;
				pulse_cnt  = '0;
				r.rev_done = 1'b1;
			end
		end else if (idle > timeout_cfg) begin
			speed_now = '0;
			rev_stamp = item.now_us;
			pulse_cnt = '0;
			r.stalled = 1'b1;
		end
		r.speed_rpm = speed_now;
		return r;
	endfunction

	task automatic note_miss(input string what, input rsp_t want, input rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: bad %s: expected speed=%0d rev_done=%b stalled=%b,",
				$realtime, what, want.speed_rpm, want.rev_done, want.stalled,
				" got speed=%0d rev_done=%b stalled=%b",
				got.speed_rpm, got.rev_done, got.stalled);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			slots_cfg   = SLOTS_RESET;
			timeout_cfg = TIMEOUT_RESET;
			pulse_cnt   = '0;
			rev_stamp   = '0;
			pulse_stamp = '0;
			speed_now   = '0;
			readings_due.delete();
		end else begin
			// an rsp at this edge belongs to an older transaction than any req at this edge
			if (rsp_valid && rsp_ready) begin
				got = rsp;
				if (readings_due.size() == 0) begin
					note_miss("reading with none due", '0, got);
				end else begin
					want = readings_due.pop_front();
					if (got.speed_rpm != want.speed_rpm)
						note_miss("speed_rpm", want, got);
					if (got.rev_done != want.rev_done)
						note_miss("rev_done", want, got);
					if (got.stalled != want.stalled)
						note_miss("stalled", want, got);
				end
			end
			if (req_valid && req_ready) begin
				want = tach_step(req);
				readings_due.push_back(want);
				seen_items++;
				if (want.rev_done)
					seen_revs++;
				if (want.stalled)
					seen_stalls++;
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_SLOTS_PER_REV:    slots_cfg   = cfg_wdata[7:0];
					REG_STALL_TIMEOUT_US: timeout_cfg = cfg_wdata;
					default: ;
				endcase
			end
		end
		pending = readings_due.size();
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the tachometer testbench: clock, reset, request/config stimulus and verdict.
// Depends on ept_pkg, encoder_period_tachometer_core and tach_checker.

module testbench;
	import ept_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	// allow some margin after draining
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned NUM_PHASES    = 8;
	// indexes the core does not decode; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned seen_items;
	int unsigned seen_revs;
	int unsigned seen_stalls;

	// stimulus knobs, shared with the receiver process
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned holds_asked    = 0;
	int unsigned holds_done     = 0;
	int unsigned hold_left      = 0;
	int unsigned cycle_count    = 0;

	// stimulus-side view of the timebase
	logic [31:0] last_pulse = '0;
	logic [31:0] tmo_now    = TIMEOUT_RESET;
	logic [31:0] base_gap   = 32'd1000;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	encoder_period_tachometer_core dut (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.cfg_we, .cfg_idx, .cfg_wdata
	);

	tach_checker scoreboard (
		.clk, .arst_n, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
		.cfg_we, .cfg_idx, .cfg_wdata, .mismatches, .pending, .seen_items,
		.seen_revs, .seen_stalls
	);

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when the stimulus asks for one,
	// so the core fills up and pushes back on req_ready
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			rsp_ready  <= 1'b0;
			hold_left  <= LONG_HOLD;
			holds_done <= holds_done + 1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// one request transaction; valid stays up after acceptance until the next call
	// or a drain lowers it at a later falling edge
	task automatic send_req(input logic kind, input logic [31:0] stamp);
		req_t item;
		item.req_type = kind;
		item.now_us   = stamp;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		if (kind == REQ_PULSE)
			last_pulse = stamp;
	endtask

	// stop offering, wait for every reading, then let the core go quiet
	task automatic drain_all;
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		if (idx == REG_STALL_TIMEOUT_US)
			tmo_now = val;
	endtask

	task automatic end_writes;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly plausible shaft motion around a base period, with checks that probe the
	// timeout boundary, and a little noise with arbitrary stamps
	task automatic random_item;
		logic        kind;
		logic [31:0] stamp;
		logic [31:0] gap;
		kind = ($urandom_range(99) < 20) ? REQ_CHECK : REQ_PULSE;
		gap  = '0;
		if ($urandom_range(99) < 5) begin
			kind  = $urandom_range(1) ? REQ_CHECK : REQ_PULSE;
			stamp = $urandom();
		end else if (kind == REQ_PULSE) begin
			case ($urandom_range(9))
				0: gap = '0;
				1: gap = $urandom_range(60);
				7: gap = $urandom_range(200000);
				8: gap = $urandom_range(4000000);
				9: gap = $urandom();
				default: gap = base_gap + $urandom_range(base_gap / 4) - base_gap / 8;
			endcase
			stamp = last_pulse + gap;
		end else begin
			case ($urandom_range(5))
				0: gap = tmo_now - 1;
				1: gap = tmo_now;
				2: gap = tmo_now + 1;
				3: gap = $urandom_range(2 * base_gap);
				4: gap = $urandom();
				default: gap = '0;
			endcase
			stamp = last_pulse + gap;
		end
		send_req(kind, stamp);
	endtask

	initial begin
		logic [31:0] stamp;
		logic [7:0]  slots;
		logic [31:0] tmo;
		int unsigned count;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed part ---
		// reset defaults: stall boundary is strict, repeated checks keep stalling
		send_req(REQ_CHECK, 32'd0);
		send_req(REQ_CHECK, 32'd500000);
		send_req(REQ_CHECK, 32'd500001);
		send_req(REQ_CHECK, 32'd600000);
		send_req(REQ_PULSE, '1);
		drain_all;

		// one slot per rev, zero timeout; spare indexes get all ones and must be ignored
		write_reg(REG_SLOTS_PER_REV, 32'd1);
		write_reg(REG_STALL_TIMEOUT_US, 32'd0);
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '1);
		end_writes;
		send_req(REQ_CHECK, 32'd1);     // stalls: clears the count, revolution starts at 1
		send_req(REQ_PULSE, 32'd0);     // span wraps past 2^32: near-zero rpm
		send_req(REQ_PULSE, 32'd0);     // zero span saturates
		send_req(REQ_PULSE, 32'd32);    // fast shaft saturates
		send_req(REQ_PULSE, 32'd1032);  // exactly 60000 rpm
		stamp = 32'd1032 + 32'd60000000;
		send_req(REQ_PULSE, stamp);     // 1 rpm
		stamp = stamp + 32'd60000001;
		send_req(REQ_PULSE, stamp);     // rounds down to 0 rpm
		send_req(REQ_CHECK, stamp);     // idle equals timeout of zero: no stall
		send_req(REQ_CHECK, stamp + 1); // one past: stall
		drain_all;

		// largest timeout can never trip, even at the largest idle span
		write_reg(REG_STALL_TIMEOUT_US, '1);
		end_writes;
		send_req(REQ_CHECK, stamp - 1);
		drain_all;
		write_reg(REG_STALL_TIMEOUT_US, 32'hFFFF_FFFE);
		end_writes;
		send_req(REQ_CHECK, stamp - 1);
		// saturation edge: 915 us saturates, 916 us does not
		stamp = stamp - 1 + 32'd915;
		send_req(REQ_PULSE, stamp);
		stamp = stamp + 32'd916;
		send_req(REQ_PULSE, stamp);
		drain_all;

		// --- random phases, one register setting each ---
		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin slots = 8'd16;  tmo = 32'd500000;     count = 200; end
				1: begin slots = 8'd1;   tmo = 32'd0;          count = 150; end
				2: begin slots = 8'd255; tmo = 32'hFFFF_FFFF;  count = 300; end
				// leaves the pulse count high, then slots drop below it and the
				// counter must wrap before the next revolution
				3: begin slots = 8'd200; tmo = 32'hFFFF_FFFF;  count = 120; end
				4: begin slots = 8'd5;   tmo = 32'hFFFF_FFFF;  count = 300; end
				// zero slots behaves as 256
				5: begin slots = 8'd0;   tmo = 32'd100000;     count = 400; end
				6: begin slots = 8'd3;   tmo = 32'd2000;       count = 200; end
				default: begin slots = 8'd8; tmo = 32'd1000000; count = 200; end
			endcase
			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
				default: begin src_idle_pct = 24; sink_stall_pct = 24; end
			endcase
			base_gap = 32'd1 << $urandom_range(16);
			base_gap = base_gap + $urandom_range(base_gap);
			write_reg(REG_SLOTS_PER_REV, 32'(slots));
			write_reg(REG_STALL_TIMEOUT_US, tmo);
			end_writes;
			if (p == NUM_PHASES - 1) begin
				// back-pressure: sender keeps offering while the receiver holds off
				src_idle_pct   = 0;
				sink_stall_pct = 0;
				holds_asked    = holds_asked + 1;
			end
			repeat (count) random_item();
			drain_all;
		end

		$display("ran %0d transactions over %0d register settings: %0d revolutions, %0d stalls",
			seen_items, NUM_PHASES + 4, seen_revs, seen_stalls);
		$display("idle mixes: none, sender 69%%, receiver 69%%, both 24%%, one long rsp hold-off");
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
rtl/core/ept_pkg.sv
rtl/core/ept_div.sv
rtl/core/encoder_period_tachometer_core.sv
test/ept_checker.sv
test/testbench.sv
